>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FBC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/fbc_pkg.sv
package fbc_pkg;

    localparam int unsigned CoordW   = 32;
    localparam int unsigned EntryW   = 32;
    localparam int unsigned CfgW     = 64;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned ProdW    = 64;
    // Exact sum of four products and its negation.
    localparam int unsigned AccW     = 67;
    localparam int unsigned CodeW    = 6;
    localparam int unsigned QueueDepth = 2;

    localparam logic [1:0] VERDICT_REJECT = 2'd0;
    localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
    localparam logic [1:0] VERDICT_INSIDE = 2'd2;

    localparam logic [CfgW-1:0] ONE_Q24 = 64'd16777216;
    localparam logic [CoordW-1:0] ONE_Q16 = 32'sd65536;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_R0_C01 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_R0_C23 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_R1_C01 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_R1_C23 = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_R2_C01 = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_R2_C23 = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_R3_C01 = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_R3_C23 = 3'd7;

    // One box in flight: the six corner extremes and the eye-inside flag.
    typedef struct packed {
        logic              eye_in;
        logic signed [CoordW-1:0] min_x;
        logic signed [CoordW-1:0] min_y;
        logic signed [CoordW-1:0] min_z;
        logic signed [CoordW-1:0] max_x;
        logic signed [CoordW-1:0] max_y;
        logic signed [CoordW-1:0] max_z;
    } t_box;

    // Matrix held as 16 signed Q8.24 entries, [row][col].
    typedef logic signed [3:0][3:0][EntryW-1:0] t_matrix;

    typedef struct packed {
        logic [1:0]       verdict;
        logic [CodeW-1:0] or_code;
        logic [CodeW-1:0] and_code;
    } t_result;

endpackage

>>> src/fbc_front.sv
module fbc_front
    import fbc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [CoordW-1:0] i_box_min_x,
    input  logic signed [CoordW-1:0] i_box_min_y,
    input  logic signed [CoordW-1:0] i_box_min_z,
    input  logic signed [CoordW-1:0] i_box_max_x,
    input  logic signed [CoordW-1:0] i_box_max_y,
    input  logic signed [CoordW-1:0] i_box_max_z,
    input  logic signed [CoordW-1:0] i_eye_x,
    input  logic signed [CoordW-1:0] i_eye_z,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_box                     o_box
);

    // Two-entry queue between the classifier and the corner engine.
    t_box                 r_q [QueueDepth];
    logic [QueueDepth-1:0] r_v;
    logic                 r_wp, r_rp;
    logic                 push, pop;
    t_box                 box;

    always_comb begin
        box.eye_in = (i_eye_x >= i_box_min_x) && (i_eye_x <= i_box_max_x) &&
                     (i_eye_z >= i_box_min_z) && (i_eye_z <= i_box_max_z);
        box.min_x = i_box_min_x;
        box.min_y = i_box_min_y;
        box.min_z = i_box_min_z;
        box.max_x = i_box_max_x;
        box.max_y = i_box_max_y;
        box.max_z = i_box_max_z;
    end

    assign o_ready = !r_v[r_wp];
    assign o_valid = r_v[r_rp];
    assign o_box   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= box;
        end
        if (!i_rst_n) begin
            r_v  <= '0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
        end else begin
            if (push) begin
                r_v[r_wp] <= 1'b1;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_v[r_rp] <= 1'b0;
                r_rp      <= ~r_rp;
            end
        end
    end

endmodule

>>> src/fbc_back.sv
module fbc_back
    import fbc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_matrix i_m,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_box    i_box,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    // Stage A (two beats per box): beat 0 does corners with z = min, beat 1 z = max.
    // 4 corners x 4 rows sharing column products: x and y terms per column,
    // one z product per row, plus the constant w column.
    logic        r_beat;
    logic        r_busy;
    t_box        r_box;

    // Stage 1 registers: products.
    logic                   r1_v, r1_last, r1_eye;
    logic signed [ProdW-1:0] r1_px [4][2];  // [row][min/max x]
    logic signed [ProdW-1:0] r1_py [4][2];
    logic signed [ProdW-1:0] r1_pz [4];
    logic signed [ProdW-1:0] r1_pw [4];

    // Stage 2: codes of four corners for this beat.
    logic                  r2_v, r2_last, r2_eye;
    logic [3:0][CodeW-1:0] r2_code;

    // Accumulated outcodes and output register.
    logic [CodeW-1:0] r_or, r_and;
    logic             r_ov;
    t_result          r_res;

    logic take, s1_en;
    logic signed [CoordW-1:0] zsel;

    // Hold the pipeline when the output is full and the receiver is not taking it.
    logic stall;
    assign stall = r_ov && !i_ready;
    assign s1_en = !stall;
    // Take the next box during the second beat or while idle, unless the pipeline stalls.
    assign o_ready = s1_en && (!r_busy || r_beat);
    assign take = i_valid && o_ready;
    assign zsel = r_beat ? r_box.max_z : r_box.min_z;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_box <= i_box;
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_beat <= 1'b0;
        end else if (s1_en) begin
            if (take) begin
                r_busy <= 1'b1;
                r_beat <= 1'b0;
            end else if (r_busy && !r_beat) begin
                r_beat <= 1'b1;
            end else begin
                r_busy <= 1'b0;
                r_beat <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            for (int r = 0; r < 4; r++) begin
                r1_px[r][0] <= ProdW'($signed(i_m[r][0]) * r_box.min_x);
                r1_px[r][1] <= ProdW'($signed(i_m[r][0]) * r_box.max_x);
                r1_py[r][0] <= ProdW'($signed(i_m[r][1]) * r_box.min_y);
                r1_py[r][1] <= ProdW'($signed(i_m[r][1]) * r_box.max_y);
                r1_pz[r]    <= ProdW'($signed(i_m[r][2]) * zsel);
                r1_pw[r]    <= ProdW'($signed(i_m[r][3]) * $signed(ONE_Q16));
            end
            r1_last <= r_beat;
            r1_eye  <= r_box.eye_in;
        end
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (s1_en) begin
            r1_v <= r_busy;
        end
    end

    // Sums and outcodes for the four corners of the beat.
    logic [3:0][CodeW-1:0] code;
    always_comb begin
        logic signed [AccW-1:0] c [4];
        logic signed [AccW-1:0] nw;
        for (int k = 0; k < 4; k++) begin
            for (int r = 0; r < 4; r++) begin
                c[r] = AccW'(r1_px[r][k[0]]) + AccW'(r1_py[r][k[1]]) +
                       AccW'(r1_pz[r]) + AccW'(r1_pw[r]);
            end
            nw = -c[3];
            code[k][0] = c[0] > c[3];
            code[k][1] = nw > c[0];
            code[k][2] = c[1] > c[3];
            code[k][3] = nw > c[1];
            code[k][4] = c[2] > c[3];
            code[k][5] = nw > c[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r2_code <= code;
            r2_last <= r1_last;
            r2_eye  <= r1_eye;
        end
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (s1_en) begin
            r2_v <= r1_v;
        end
    end

    logic [CodeW-1:0] b_or, b_and, f_or, f_and;
    assign b_or  = r2_code[0] | r2_code[1] | r2_code[2] | r2_code[3];
    assign b_and = r2_code[0] & r2_code[1] & r2_code[2] & r2_code[3];
    assign f_or  = r_or | b_or;
    assign f_and = r_and & b_and;

    always_ff @(posedge i_clk) begin
        if (s1_en && r2_v) begin
            if (!r2_last) begin
                r_or  <= b_or;
                r_and <= b_and;
            end else begin
                r_res.or_code  <= r2_eye ? '0 : f_or;
                r_res.and_code <= r2_eye ? '0 : f_and;
                priority if (r2_eye) begin
                    r_res.verdict <= VERDICT_PARTIAL;
                end else if (f_and != '0) begin
                    r_res.verdict <= VERDICT_REJECT;
                end else if (f_or == '0) begin
                    r_res.verdict <= VERDICT_INSIDE;
                end else begin
                    r_res.verdict <= VERDICT_PARTIAL;
                end
            end
        end
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s1_en && r2_v && r2_last) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

>>> src/frustum_box_cull.sv
// An accepted box goes through the queue, two beats, sum/code and output to its result.
// A new box enters in the second beat unless stalled; the engine spends two beats per box,
//   handling four corners a beat with 24 shared Q8.24 x Q16.16 multipliers.
// Reset: synchronous, active low; clears all handshake state and loads the identity
//   matrix. Payload registers are not reset.
module frustum_box_cull
    import fbc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgW-1:0]     i_cfg_data,
    // Box stream in.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata, low bit up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
    //   box_max_z, eye_x, eye_z (32 bits each).
    input  logic [255:0]        s_axis_tdata,
    // Verdict stream out.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata, low bit up: verdict[1:0], or_outcode[7:2], and_outcode[13:8], zeros.
    output logic [15:0]         m_axis_tdata
);

    logic [7:0][CfgW-1:0] r_cfg;
    logic [7:0][CfgW-1:0] cfg_rst;
    t_matrix m;

    // Identity matrix loaded at reset.
    always_comb begin
        cfg_rst             = '0;
        cfg_rst[REG_R0_C01] = ONE_Q24;
        cfg_rst[REG_R1_C01] = ONE_Q24 << 32;
        cfg_rst[REG_R2_C23] = ONE_Q24;
        cfg_rst[REG_R3_C23] = ONE_Q24 << 32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= cfg_rst;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Unpack rows: column 0/2 in the low half, 1/3 in the high half.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            m[r][0] = r_cfg[2*r][31:0];
            m[r][1] = r_cfg[2*r][63:32];
            m[r][2] = r_cfg[2*r+1][31:0];
            m[r][3] = r_cfg[2*r+1][63:32];
        end
    end

    logic q_valid, q_ready;
    t_box q_box;
    t_result res;

    fbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_box_min_x(s_axis_tdata[31:0]),
        .i_box_min_y(s_axis_tdata[63:32]),
        .i_box_min_z(s_axis_tdata[95:64]),
        .i_box_max_x(s_axis_tdata[127:96]),
        .i_box_max_y(s_axis_tdata[159:128]),
        .i_box_max_z(s_axis_tdata[191:160]),
        .i_eye_x    (s_axis_tdata[223:192]),
        .i_eye_z    (s_axis_tdata[255:224]),
        .o_valid    (q_valid),
        .i_ready    (q_ready),
        .o_box      (q_box)
    );

    fbc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_m    (m),
        .i_valid(q_valid),
        .o_ready(q_ready),
        .i_box  (q_box),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_res  (res)
    );

    assign m_axis_tdata = {2'b00, res.and_code, res.or_code, res.verdict};

endmodule

>>> src/fbc_checker.sv
`include "assert_macros.svh"
module fbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    `FBC_ASSERT_IMPL(a_verdict_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3, "verdict out of range")
    `FBC_ASSERT_IMPL(a_and_in_or, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[13:8] & ~m_axis_tdata[7:2]) == 6'd0, "and not within or")
    `FBC_ASSERT_IMPL(a_reject, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[13:8] != 6'd0, m_axis_tdata[1:0] == 2'd0, "reject mismatch")
    `FBC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output dropped")
endmodule

bind frustum_box_cull fbc_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

>>> test/frustum_box_cull_tb.sv
module frustum_box_cull_tb;
    import fbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgW-1:0]    i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // Fields from bit 0 up: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
    // box_max_z, eye_x, eye_z, 32 bits each.
    logic [255:0]       s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // Fields from bit 0 up: verdict[1:0], or_outcode[7:2], and_outcode[13:8], zeros.
    logic [15:0]        m_axis_tdata;

    typedef struct {
        logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, eye_x, eye_z;
    } t_test_box;

    logic [CfgW-1:0] matrix_regs [8];
    t_result         verdict_q [$];
    int              errors;
    int              stall_pct;
    int              burst_left;

    frustum_box_cull DUT (.*);

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Hard limit far above the slowest correct run.
    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic signed [AccW-1:0] row_dot(int r, logic signed [31:0] x,
                                                       logic signed [31:0] y,
                                                       logic signed [31:0] z);
        logic signed [31:0] m0, m1, m2, m3;
        logic signed [AccW-1:0] acc;
        m0 = matrix_regs[2*r][31:0];
        m1 = matrix_regs[2*r][63:32];
        m2 = matrix_regs[2*r+1][31:0];
        m3 = matrix_regs[2*r+1][63:32];
        acc = AccW'(m0 * 64'(x)) + AccW'(64'(m1) * y) + AccW'(64'(m2) * z)
            + AccW'(64'(m3) * 64'sd65536);
        return acc;
    endfunction

    function automatic t_result cull_verdict(t_test_box b);
        t_result res;
        logic signed [31:0] x, y, z;
        logic signed [AccW-1:0] cx, cy, cz, cw, nw;
        logic [CodeW-1:0] code, c_or, c_and;
        c_or = '0;
        c_and = '1;
        if (b.eye_x >= b.lo_x && b.eye_x <= b.hi_x && b.eye_z >= b.lo_z &&
            b.eye_z <= b.hi_z) begin
            res.verdict = VERDICT_PARTIAL;
            res.or_code = '0;
            res.and_code = '0;
            return res;
        end
        for (int i = 0; i < 8; i++) begin
            x = i[0] ? b.hi_x : b.lo_x;
            y = i[1] ? b.hi_y : b.lo_y;
            z = i[2] ? b.hi_z : b.lo_z;
            cx = row_dot(0, x, y, z);
            cy = row_dot(1, x, y, z);
            cz = row_dot(2, x, y, z);
            cw = row_dot(3, x, y, z);
            nw = -cw;
            code = {nw > cz, cz > cw, nw > cy, cy > cw, nw > cx, cx > cw};
            c_or |= code;
            c_and &= code;
        end
        res.or_code = c_or;
        res.and_code = c_and;
        res.verdict = (c_and != 0) ? VERDICT_REJECT : (c_or != 0) ? VERDICT_PARTIAL
                                                                 : VERDICT_INSIDE;
        return res;
    endfunction

    // Compare each result item against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[1:0] != want.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d", $time,
                             want.verdict, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[7:2] != want.or_code) begin
                    $display("%0t: or_outcode expected %h actual %h", $time,
                             want.or_code, m_axis_tdata[7:2]);
                    errors++;
                end
                if (m_axis_tdata[13:8] != want.and_code) begin
                    $display("%0t: and_outcode expected %h actual %h", $time,
                             want.and_code, m_axis_tdata[13:8]);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure: stall pattern on its own, changed at the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold the write enable across consecutive writes; the caller drops it.
    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        matrix_regs[idx] = val;
        @(negedge i_clk);
    endtask

    // Hold until every prediction is consumed, then let the pipeline drain.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Keep tvalid high within a burst; drop it only for the gap before the next one.
    task automatic send_box(t_test_box b);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
            burst_left = $urandom_range(12, 1);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b.eye_z, b.eye_x, b.hi_z, b.hi_y, b.hi_x, b.lo_z, b.lo_y, b.lo_x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(cull_verdict(b));
        @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
        endcase
    endfunction

    function automatic t_test_box rand_box();
        t_test_box b;
        logic signed [31:0] t;
        b.lo_x = rand_coord(); b.lo_y = rand_coord(); b.lo_z = rand_coord();
        b.hi_x = rand_coord(); b.hi_y = rand_coord(); b.hi_z = rand_coord();
        // Mostly well-ordered boxes; leave some inverted.
        if ($urandom_range(9) != 0) begin
            if (b.lo_x > b.hi_x) begin t = b.lo_x; b.lo_x = b.hi_x; b.hi_x = t; end
            if (b.lo_y > b.hi_y) begin t = b.lo_y; b.lo_y = b.hi_y; b.hi_y = t; end
            if (b.lo_z > b.hi_z) begin t = b.lo_z; b.lo_z = b.hi_z; b.hi_z = t; end
        end
        b.eye_x = rand_coord();
        b.eye_z = rand_coord();
        // Put the eye inside now and then.
        if ($urandom_range(4) == 0) begin
            b.eye_x = b.lo_x;
            b.eye_z = b.hi_z;
        end
        return b;
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $signed($urandom_range(4 * 16777216)) - 2 * 16777216;
        endcase
    endfunction

    function automatic t_test_box mk(int lx, int ly, int lz, int hx, int hy, int hz,
                                     int ex, int ez);
        t_test_box b;
        b.lo_x = lx; b.lo_y = ly; b.lo_z = lz;
        b.hi_x = hx; b.hi_y = hy; b.hi_z = hz;
        b.eye_x = ex; b.eye_z = ez;
        return b;
    endfunction

    // Identity matrix: wholly inside, partly, rejected on every plane, eye inside, inverted, extremes.
    task automatic test_directed();
        int h;
        h = 32768;
        send_box(mk(-h, -h, -h, h, h, h, 2 * 65536, 0));
        send_box(mk(-h, -h, -h, 3 * 65536, h, h, 5 * 65536, 0));
        send_box(mk(2 * 65536, -h, -h, 3 * 65536, h, h, 9 * 65536, 0));
        send_box(mk(-3 * 65536, -h, -h, -2 * 65536, h, h, 9 * 65536, 0));
        send_box(mk(-h, 2 * 65536, -h, h, 3 * 65536, h, 9 * 65536, 0));
        send_box(mk(-h, -3 * 65536, -h, h, -2 * 65536, h, 9 * 65536, 0));
        send_box(mk(-h, -h, 2 * 65536, h, h, 3 * 65536, 9 * 65536, 0));
        send_box(mk(-h, -h, -3 * 65536, h, h, -2 * 65536, 9 * 65536, 0));
        send_box(mk(-h, -h, -h, h, h, h, 0, 0));
        send_box(mk(-h, -h, -h, h, h, h, h, -h));
        send_box(mk(h, h, h, -h, -h, -h, 0, 0));
        send_box(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_box(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send_box(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                    32'h80000000, 32'h80000000, 0, 0));
        send_box(mk(-1, -1, -1, -1, -1, -1, 0, -1));
        drain();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_box(rand_box());
    endtask

    // Load a new matrix while idle; extremes included.
    task automatic test_matrix(int kind);
        for (int r = 0; r < 8; r++) begin
            case (kind)
                0: write_reg(CfgIdxW'(r), {32'h7fffffff, 32'h80000000});
                1: write_reg(CfgIdxW'(r), {32'h80000000, 32'h7fffffff});
                2: write_reg(CfgIdxW'(r), '0);
                default: write_reg(CfgIdxW'(r), {rand_entry(), rand_entry()});
            endcase
        end
        i_cfg_we <= 1'b0;
        // The 3-bit index covers all entries of the 8-entry map, so none is out of range.
    endtask

    initial begin
        errors = 0;
        stall_pct = 30;
        burst_left = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        matrix_regs[REG_R0_C01] = ONE_Q24;
        matrix_regs[REG_R0_C23] = '0;
        matrix_regs[REG_R1_C01] = ONE_Q24 << 32;
        matrix_regs[REG_R1_C23] = '0;
        matrix_regs[REG_R2_C01] = '0;
        matrix_regs[REG_R2_C23] = ONE_Q24;
        matrix_regs[REG_R3_C01] = '0;
        matrix_regs[REG_R3_C23] = ONE_Q24 << 32;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(100);
        drain();
        for (int k = 0; k < 4; k++) begin
            test_matrix(k);
            stall_pct = (k == 1) ? 0 : (k == 2) ? 80 : 30;
            test_random(40);
            drain();
        end
        for (int k = 0; k < 3; k++) begin
            test_matrix(3);
            test_random(70);
            drain();
        end

        repeat (20) @(negedge i_clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
